// ===== hw/rtl/mm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiply engine
// Matrix size limits, store geometry, opcodes, register indexes, the
// sequencer state type and the tag that travels down the MAC pipeline.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CFG_W      = 4;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int ENTRY_W    = 16;
    localparam int PROD_W     = 2 * ENTRY_W;
    localparam int SUM_W      = 35;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Bookkeeping carried with each multiply term.
    typedef struct packed {
        logic             first_k;
        logic             last_k;
        logic             last_entry;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } mm_tag_t;

    // Saturate a written dimension into 1..MAX_DIM.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] v;
        v = value;
        if (v == '0) begin
            v = CFG_W'(1);
        end
        if (v > CFG_W'(MAX_DIM)) begin
            v = CFG_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage : mm_pkg
`default_nettype wire

// ===== hw/rtl/mm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule : mm_ram
`default_nettype wire

// ===== hw/rtl/matrix_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply: dense fixed-point matrix product engine
// Stores A and B in two RAMs and streams C = A x B through one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Load
// requests (opcode 0 for A, 1 for B) write one Q8.8 entry and keep busy
// low. A compute request (opcode 2) raises busy and emits every entry of C
// in row-major order, one per result_valid pulse; each pulse lasts exactly
// one cycle and cannot be held off, so capture the result then. One
// multiply-accumulate unit walks the inner dimension, one term per cycle,
// and busy stays high while the terms issue and while the last term passes
// RAM read, multiply and accumulate; its result pulses in the final busy
// cycle. Opcode 3 is ignored. Write the dimension registers only while busy
// is low; 0 reads as 1 and values above 8 read as 8.
// Entries of A and B must be loaded before a compute uses them.
// ----------------------------------------------------------------------------
module matrix_multiply
    import mm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          opcode,
    input  wire logic [DIM_W-1:0]    row_index,
    input  wire logic [DIM_W-1:0]    col_index,
    input  wire logic signed [ENTRY_W-1:0] entry_value,
    // configuration write port
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    // result channel
    output logic                     result_valid,
    output logic [DIM_W-1:0]         out_row,
    output logic [DIM_W-1:0]         out_col,
    output logic signed [SUM_W-1:0]  product_value,
    output logic                     last_entry
);

    // ------------------------------------------------------------------
    // Dimension registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(MAX_DIM);
            inner_dim_reg <= CFG_W'(MAX_DIM);
            cols_b_reg    <= CFG_W'(MAX_DIM);
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ROWS_A:    rows_a_reg    <= clamp_dim(cfg_data);
                REG_INNER_DIM: inner_dim_reg <= clamp_dim(cfg_data);
                REG_COLS_B:    cols_b_reg    <= clamp_dim(cfg_data);
                default:       ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode: loads go straight into the stores
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   req_accept;
    logic   load_a;
    logic   load_b;
    logic   compute_req;

    assign busy        = (state_reg != ST_IDLE);
    assign req_accept  = start && !busy;
    assign load_a      = req_accept && (opcode_t'(opcode) == OP_LOAD_A);
    assign load_b      = req_accept && (opcode_t'(opcode) == OP_LOAD_B);
    assign compute_req = req_accept && (opcode_t'(opcode) == OP_COMPUTE);

    // ------------------------------------------------------------------
    // Sequencer: walk i (row), j (col), k (inner) one term per cycle
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic             issue;
    logic             k_done;
    logic             j_done;
    logic             i_done;
    mm_tag_t          issue_tag;

    assign k_done = ({1'b0, k_reg} == (inner_dim_reg - CFG_W'(1)));
    assign j_done = ({1'b0, j_reg} == (cols_b_reg - CFG_W'(1)));
    assign i_done = ({1'b0, i_reg} == (rows_a_reg - CFG_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    logic s1_valid_reg;
    logic s2_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (compute_req)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (k_done)
                begin
                    k_next = '0;
                    if (j_done)
                    begin
                        j_next = '0;
                        if (i_done)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + DIM_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // hold until the last term has left the MAC pipeline
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign issue_tag.first_k    = (k_reg == '0);
    assign issue_tag.last_k     = k_done;
    assign issue_tag.last_entry = k_done && j_done && i_done;
    assign issue_tag.row        = i_reg;
    assign issue_tag.col        = j_reg;

    // ------------------------------------------------------------------
    // Matrix stores: entry (r,c) at r*MAX_DIM + c
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] a_rd_data;
    logic [ENTRY_W-1:0] b_rd_data;

    mm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_left_store (
        .clk     (clk),
        .wr_en   (load_a),
        .wr_addr ({row_index, col_index}),
        .wr_data (entry_value),
        .rd_addr ({i_reg, k_reg}),
        .rd_data (a_rd_data)
    );

    mm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_right_store (
        .clk     (clk),
        .wr_en   (load_b),
        .wr_addr ({row_index, col_index}),
        .wr_data (entry_value),
        .rd_addr ({k_reg, j_reg}),
        .rd_data (b_rd_data)
    );

    // ------------------------------------------------------------------
    // MAC pipeline: stage 1 = RAM read, stage 2 = product, stage 3 = sum
    // ------------------------------------------------------------------
    mm_tag_t                   s1_tag_reg;
    mm_tag_t                   s2_tag_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            result_valid <= s2_valid_reg && s2_tag_reg.last_k;
        end
    end

    // Start a fresh sum on the first term of each entry.
    assign acc_next = (s2_tag_reg.first_k ? SUM_W'(0) : acc_reg)
                    + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= $signed(a_rd_data) * $signed(b_rd_data);
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_tag_reg.last_k)
        begin
            out_row       <= s2_tag_reg.row;
            out_col       <= s2_tag_reg.col;
            product_value <= acc_next;
            last_entry    <= s2_tag_reg.last_entry;
        end
    end

endmodule : matrix_multiply
`default_nettype wire
